// ===== sv/snt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types and constants for the sorted note table lookup unit.
// ----------------------------------------------------------------------------
package snt_pkg;

    localparam int NOTE_W          = 7;
    localparam int INDEX_W         = 5;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 6;
    localparam int OPCODE_W        = 2;
    localparam int DEF_MAX_ENTRIES = 32;

    // Command codes. Any code with the high bit set is treated as a lookup.
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
    localparam int                  OP_LOOKUP_BIT = 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Outcome of the shared compare unit.
    typedef struct packed {
        logic              eq;
        logic              lt;
        logic              gt;
        logic [NOTE_W-1:0] delta;
    } t_cmp;

endpackage

// ===== sv/sorted_note_table_nearest_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_note_table_nearest_lookup_unit
// Table of root note numbers with append, sorted insert and nearest lookup.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word
//  command   in         start, busy          i_opcode, i_note
//  result    out        o_strobe (no stall)  o_index, o_root_note, o_status,
//                                            o_entry_count
//
// A command word is taken on a clock edge with start high and busy low; busy
// then stays high until the cycle in which the result word is shown, so one
// command is in flight at a time. An append goes straight to the write. A
// sorted insert scans upward for the first entry above the note, shifts the
// entries from there up by one, working down from the top, and writes the
// note into the freed place, all paced by the single read port of the table.
// A lookup runs bisection steps, each a probe and a check, stops on an exact
// match, else loads both ends of the final pair and picks. A full table on
// an append or insert, or an empty one on a lookup, never raises busy.
// The result word is shown for one cycle on o_strobe and cannot be held off.
// The reset is synchronous and active low; it empties the table at once, the
// stored notes themselves are never cleared because only filled entries are
// ever read.
// ----------------------------------------------------------------------------
module sorted_note_table_nearest_lookup_unit #(
    parameter int MAX_ENTRIES = snt_pkg::DEF_MAX_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [snt_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [snt_pkg::NOTE_W-1:0]   i_note,
    output logic                         o_strobe,
    output logic [snt_pkg::INDEX_W-1:0]  o_index,
    output logic [snt_pkg::NOTE_W-1:0]   o_root_note,
    output logic [snt_pkg::STATUS_W-1:0] o_status,
    output logic [snt_pkg::COUNT_W-1:0]  o_entry_count
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = snt_pkg::NOTE_W;

    // Sequencer states. The insert path scans, shifts and writes; the lookup
    // path probes, checks, then loads both ends of the final pair and picks.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_SHIFT = 9'b000000100,
        S_WRITE = 9'b000001000,
        S_PROBE = 9'b000010000,
        S_CHECK = 9'b000100000,
        S_LO    = 9'b001000000,
        S_HI    = 9'b010000000,
        S_PICK  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos,   n_pos;
    logic [CW-1:0] r_ptr,   n_ptr;
    logic [AW-1:0] r_caddr, n_caddr;
    logic          r_pend,  n_pend;
    logic          r_stop,  n_stop;
    logic [AW-1:0] r_lo,    n_lo;
    logic [AW-1:0] r_hi,    n_hi;
    logic [NW-1:0] r_note,  n_note;
    logic [NW-1:0] r_dlo,   n_dlo;
    logic [NW-1:0] r_dhi,   n_dhi;
    logic [NW-1:0] r_lo_note, n_lo_note;
    logic [NW-1:0] r_hi_note, n_hi_note;

    logic                         r_strobe, n_strobe;
    logic [snt_pkg::INDEX_W-1:0]  r_index,  n_index;
    logic [NW-1:0]                r_root,   n_root;
    logic [snt_pkg::STATUS_W-1:0] r_status, n_status;
    logic [snt_pkg::COUNT_W-1:0]  r_ecount, n_ecount;

    // Table port and shared unit operands.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [NW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [NW-1:0] w_rdata;
    logic [NW-1:0] w_alu_a;
    logic [NW-1:0] w_alu_b;
    snt_pkg::t_cmp w_cmp;

    logic [AW:0]   w_mid_sum;
    logic [AW-1:0] w_mid;
    logic          w_wide_gap;
    logic          w_full;

    assign w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_mid_sum[AW:1];
    assign w_wide_gap = (({1'b0, r_lo} + (AW + 1)'(1)) < {1'b0, r_hi});
    assign w_full     = (r_count == CW'(MAX_ENTRIES));

    snt_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The final pick compares the two stored distances; every other use
    // compares the word just read against the command note.
    assign w_alu_a = (r_state == S_PICK) ? r_dlo : w_rdata;
    assign w_alu_b = (r_state == S_PICK) ? r_dhi : r_note;

    snt_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_cmp)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_ptr     = r_ptr;
        n_caddr   = r_caddr;
        n_pend    = 1'b0;
        n_stop    = r_stop;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_note    = r_note;
        n_dlo     = r_dlo;
        n_dhi     = r_dhi;
        n_lo_note = r_lo_note;
        n_hi_note = r_hi_note;
        n_strobe  = 1'b0;
        n_index   = r_index;
        n_root    = r_root;
        n_status  = r_status;
        n_ecount  = r_ecount;
        w_we      = 1'b0;
        w_waddr   = AW'(r_pos);
        w_wdata   = r_note;
        w_raddr   = AW'(r_ptr);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_note = i_note;
                    n_ptr  = '0;
                    if (i_opcode[snt_pkg::OP_LOOKUP_BIT]) begin
                        if (r_count == '0) begin
                            n_strobe = 1'b1;
                            n_index  = '0;
                            n_root   = '0;
                            n_status = snt_pkg::ST_EMPTY;
                            n_ecount = snt_pkg::COUNT_W'(r_count);
                        end else begin
                            n_lo    = '0;
                            n_hi    = AW'(r_count - CW'(1));
                            n_state = S_PROBE;
                        end
                    end else if (w_full) begin
                        n_strobe = 1'b1;
                        n_index  = '0;
                        n_root   = '0;
                        n_status = snt_pkg::ST_FULL;
                        n_ecount = snt_pkg::COUNT_W'(r_count);
                    end else if (i_opcode == snt_pkg::OP_INSERT && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_pos   = r_count;
                        n_state = S_WRITE;
                    end
                end
            end

            S_SCAN: begin
                if (r_pend && w_cmp.gt) begin
                    n_pos   = CW'(r_caddr);
                    n_ptr   = r_count - CW'(1);
                    n_stop  = 1'b0;
                    n_state = S_SHIFT;
                end else if (r_pend && (CW'(r_caddr) + CW'(1)) == r_count) begin
                    n_pos   = r_count;
                    n_state = S_WRITE;
                end else if (r_ptr < r_count) begin
                    n_caddr = AW'(r_ptr);
                    n_pend  = 1'b1;
                    n_ptr   = r_ptr + CW'(1);
                end
            end

            S_SHIFT: begin
                // Move the word read last cycle up by one while reading the
                // next one below it.
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(CW'(r_caddr) + CW'(1));
                    w_wdata = w_rdata;
                end
                if (r_pend && CW'(r_caddr) == r_pos) begin
                    n_state = S_WRITE;
                end else if (!r_stop) begin
                    n_caddr = AW'(r_ptr);
                    n_pend  = 1'b1;
                    if (r_ptr == r_pos) begin
                        n_stop = 1'b1;
                    end else begin
                        n_ptr = r_ptr - CW'(1);
                    end
                end
            end

            S_WRITE: begin
                w_we     = 1'b1;
                w_waddr  = AW'(r_pos);
                w_wdata  = r_note;
                n_count  = r_count + CW'(1);
                n_strobe = 1'b1;
                n_index  = snt_pkg::INDEX_W'(r_pos);
                n_root   = r_note;
                n_status = snt_pkg::ST_OK;
                n_ecount = snt_pkg::COUNT_W'(r_count + CW'(1));
                n_state  = S_IDLE;
            end

            S_PROBE: begin
                if (w_wide_gap) begin
                    w_raddr = w_mid;
                    n_caddr = w_mid;
                    n_state = S_CHECK;
                end else begin
                    w_raddr = r_lo;
                    n_state = S_LO;
                end
            end

            S_CHECK: begin
                if (w_cmp.eq) begin
                    n_strobe = 1'b1;
                    n_index  = snt_pkg::INDEX_W'(r_caddr);
                    n_root   = w_rdata;
                    n_status = snt_pkg::ST_OK;
                    n_ecount = snt_pkg::COUNT_W'(r_count);
                    n_state  = S_IDLE;
                end else begin
                    if (w_cmp.lt) begin
                        n_lo = r_caddr;
                    end else begin
                        n_hi = r_caddr;
                    end
                    n_state = S_PROBE;
                end
            end

            S_LO: begin
                n_dlo     = w_cmp.delta;
                n_lo_note = w_rdata;
                w_raddr   = r_hi;
                n_state   = S_HI;
            end

            S_HI: begin
                n_dhi     = w_cmp.delta;
                n_hi_note = w_rdata;
                n_state   = S_PICK;
            end

            S_PICK: begin
                // A tie goes to the upper entry.
                n_strobe = 1'b1;
                n_status = snt_pkg::ST_OK;
                n_ecount = snt_pkg::COUNT_W'(r_count);
                if (w_cmp.lt) begin
                    n_index = snt_pkg::INDEX_W'(r_lo);
                    n_root  = r_lo_note;
                end else begin
                    n_index = snt_pkg::INDEX_W'(r_hi);
                    n_root  = r_hi_note;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_stop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_stop   <= n_stop;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_ptr     <= n_ptr;
        r_caddr   <= n_caddr;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_note    <= n_note;
        r_dlo     <= n_dlo;
        r_dhi     <= n_dhi;
        r_lo_note <= n_lo_note;
        r_hi_note <= n_hi_note;
        r_index   <= n_index;
        r_root    <= n_root;
        r_status  <= n_status;
        r_ecount  <= n_ecount;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_index       = r_index;
    assign o_root_note   = r_root;
    assign o_status      = r_status;
    assign o_entry_count = r_ecount;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("fill count beyond table depth");

    // The fill count moves only together with a result word.
    a_count_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> r_strobe)
        else $error("fill count changed without a result");

    // A full report is only given when the table really is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == snt_pkg::ST_FULL) |-> w_full)
        else $error("full status with room left");

    // The bisection window stays ordered while a lookup runs.
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CHECK) |-> (r_lo <= r_hi))
        else $error("lookup window inverted");

endmodule

// ===== sv/snt_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_alu
// Shared compare unit: ordering of two notes and their absolute distance.
// ----------------------------------------------------------------------------
module snt_alu (
    input  logic [snt_pkg::NOTE_W-1:0] i_a,
    input  logic [snt_pkg::NOTE_W-1:0] i_b,
    output snt_pkg::t_cmp              o_res
);

    logic [snt_pkg::NOTE_W:0] w_diff;

    assign w_diff      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.eq    = (i_a == i_b);
    assign o_res.lt    = w_diff[snt_pkg::NOTE_W];
    assign o_res.gt    = !w_diff[snt_pkg::NOTE_W] && (i_a != i_b);
    assign o_res.delta = w_diff[snt_pkg::NOTE_W] ? (i_b - i_a)
                                                 : w_diff[snt_pkg::NOTE_W-1:0];

endmodule

// ===== sv/snt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_ram
// Note table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module snt_ram #(
    parameter int DEPTH = snt_pkg::DEF_MAX_ENTRIES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [snt_pkg::NOTE_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [snt_pkg::NOTE_W-1:0] o_rdata
);

    logic [snt_pkg::NOTE_W-1:0] r_mem [DEPTH];
    logic [snt_pkg::NOTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
